// ===== sv/smt_pkg.sv =====
// smt_pkg: item types, request and status codes, and the controller-to-datapath
// command and status types for the sorted multiset table.
// No dependencies.
`timescale 1ns / 1ps

package smt_pkg;

   // Request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         occupancy;
      logic               smallest_valid;
      logic signed [31:0] smallest_value;
   } rsp_item_type;

   // Datapath operations
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD_INS,   // latch operand, index <= count
      DP_LOAD_RM,    // latch operand, index <= 0
      DP_RD_BELOW,   // read entry index-1
      DP_RD_AT,      // read entry index
      DP_RD_ABOVE,   // read entry index+1
      DP_SHIFT_UP,   // entry index <= read data, index--
      DP_PUT,        // entry index <= operand, count++
      DP_NEXT,       // index++
      DP_SHIFT_DN,   // entry index <= read data, index++
      DP_DROP,       // count--
      DP_CLEAR       // count <= 0
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       rsp_load;
      logic [1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic full;      // count at capacity
      logic idx_zero;  // index is 0
      logic idx_end;   // index equals count
      logic idx_last;  // index+1 equals count
      logic rd_gt;     // read data greater than operand
      logic rd_eq;     // read data equal to operand
   } dp_stat_type;

endpackage

// ===== sv/smt_datapath.sv =====
// smt_datapath: entry memory, count, index counter, operand and read
// registers, cached smallest value and the result register.
// Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smt_pkg::dp_cmd_type   cmd,
   input  logic signed [31:0]    req_value,
   output smt_pkg::dp_stat_type  stat,
   output smt_pkg::rsp_item_type rsp_item
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [31:0] mem [CAPACITY];

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic signed [31:0]    value_ff;
   logic signed [31:0]    rdata_ff;
   logic signed [31:0]    smallest_ff;
   smt_pkg::rsp_item_type rsp_ff;

   logic [CNT_W-1:0]   idx_dec, idx_inc;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic               rd_en, wr_en;
   logic signed [31:0] wr_data;

   assign idx_dec = idx_ff - CNT_W'(1);
   assign idx_inc = idx_ff + CNT_W'(1);
   assign wr_addr = idx_ff[IDX_W-1:0];

   // Read address and write port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_data = rdata_ff;
      case (cmd.op)
         smt_pkg::DP_RD_BELOW: begin
            rd_en   = 1'b1;
            rd_addr = idx_dec[IDX_W-1:0];
         end
         smt_pkg::DP_RD_AT: begin
            rd_en = 1'b1;
         end
         smt_pkg::DP_RD_ABOVE: begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[IDX_W-1:0];
         end
         smt_pkg::DP_SHIFT_UP, smt_pkg::DP_SHIFT_DN: begin
            wr_en = 1'b1;
         end
         smt_pkg::DP_PUT: begin
            wr_en   = 1'b1;
            wr_data = value_ff;
         end
         default: begin
         end
      endcase
   end

   // Count and index next values
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      case (cmd.op)
         smt_pkg::DP_LOAD_INS: idx_in   = count_ff;
         smt_pkg::DP_LOAD_RM:  idx_in   = '0;
         smt_pkg::DP_SHIFT_UP: idx_in   = idx_dec;
         smt_pkg::DP_NEXT:     idx_in   = idx_inc;
         smt_pkg::DP_SHIFT_DN: idx_in   = idx_inc;
         smt_pkg::DP_PUT:      count_in = count_ff + CNT_W'(1);
         smt_pkg::DP_DROP:     count_in = count_ff - CNT_W'(1);
         smt_pkg::DP_CLEAR:    count_in = '0;
         default: begin
         end
      endcase
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload registers; smallest tracks every write to entry 0
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.op == smt_pkg::DP_LOAD_INS || cmd.op == smt_pkg::DP_LOAD_RM) begin
         value_ff <= req_value;
      end
      if (wr_en && wr_addr == '0) begin
         smallest_ff <= wr_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status         <= cmd.rsp_status;
         rsp_ff.occupancy      <= 7'(count_ff);
         rsp_ff.smallest_valid <= (count_ff != '0);
         rsp_ff.smallest_value <= (count_ff != '0) ? smallest_ff : 32'sd0;
      end
   end

   // Status to the controller
   always_comb begin
      stat.full     = (count_ff == CNT_W'(CAPACITY));
      stat.idx_zero = (idx_ff == '0);
      stat.idx_end  = (idx_ff == count_ff);
      stat.idx_last = ((CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(count_ff);
      stat.rd_gt    = (rdata_ff > value_ff);
      stat.rd_eq    = (rdata_ff == value_ff);
   end

   assign rsp_item = rsp_ff;

endmodule

// ===== sv/smt_ctrl.sv =====
// smt_ctrl: request sequencer for the sorted multiset table; walks insert
// and remove through the datapath and owns both handshakes.
// Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_code,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  smt_pkg::dp_stat_type stat,
   output smt_pkg::dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_RM_RD,
      S_RM_CMP,
      S_SH_RD,
      S_SH_WR,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath command
   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd.op         = smt_pkg::DP_NOP;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = smt_pkg::STAT_DONE;
               state_in  = S_FINISH;
               case (req_code)
                  smt_pkg::REQ_INSERT: begin
                     if (stat.full) begin
                        status_in = smt_pkg::STAT_FULL;
                     end else begin
                        cmd.op   = smt_pkg::DP_LOAD_INS;
                        state_in = S_INS_RD;
                     end
                  end
                  smt_pkg::REQ_REMOVE: begin
                     cmd.op   = smt_pkg::DP_LOAD_RM;
                     state_in = S_RM_RD;
                  end
                  smt_pkg::REQ_CLEAR: begin
                     cmd.op = smt_pkg::DP_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Insert: walk down from the top, shifting larger entries up
         S_INS_RD: begin
            if (stat.idx_zero) begin
               cmd.op   = smt_pkg::DP_PUT;
               state_in = S_FINISH;
            end else begin
               cmd.op   = smt_pkg::DP_RD_BELOW;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (stat.rd_gt) begin
               cmd.op   = smt_pkg::DP_SHIFT_UP;
               state_in = S_INS_RD;
            end else begin
               cmd.op   = smt_pkg::DP_PUT;
               state_in = S_FINISH;
            end
         end
         // Remove: search up for the first match
         S_RM_RD: begin
            if (stat.idx_end) begin
               status_in = smt_pkg::STAT_NOT_FOUND;
               state_in  = S_FINISH;
            end else begin
               cmd.op   = smt_pkg::DP_RD_AT;
               state_in = S_RM_CMP;
            end
         end
         S_RM_CMP: begin
            if (stat.rd_eq) begin
               state_in = S_SH_RD;
            end else begin
               cmd.op   = smt_pkg::DP_NEXT;
               state_in = S_RM_RD;
            end
         end
         // Close the gap by shifting later entries down
         S_SH_RD: begin
            if (stat.idx_last) begin
               cmd.op   = smt_pkg::DP_DROP;
               state_in = S_FINISH;
            end else begin
               cmd.op   = smt_pkg::DP_RD_ABOVE;
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.op   = smt_pkg::DP_SHIFT_DN;
            state_in = S_SH_RD;
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= smt_pkg::STAT_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/sorted_multiset_table.sv =====
// sorted_multiset_table: top level; bounded ascending store of signed values
// with insert, remove-one and clear. Depends on smt_pkg, smt_ctrl, smt_datapath.
//
//   Channel   Ports                               Direction
//   request   req_valid, req_ready, req_item      in
//   result    rsp_valid, rsp_ready, rsp_item      out
//
// One item at a time through an entry memory with one write and one registered
// read port. Insert shifts each entry larger than the value up one place, then
// puts the value in. Remove compares entries up to the first match, shifts each
// later entry down and drops the count; an absent value is compared with every
// entry. Clear, full insert and unused codes go straight to the result. A result
// may wait in its register while the next item is accepted; a stalled result
// holds the sequencer in its final step. Synchronous reset empties the store at once.
`timescale 1ns / 1ps

module sorted_multiset_table #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  smt_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output smt_pkg::rsp_item_type rsp_item
);

   smt_pkg::dp_cmd_type  cmd;
   smt_pkg::dp_stat_type stat;

   smt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_code  (req_item.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   smt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_item.value),
      .stat      (stat),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== test/smt_checker.sv =====
// smt_checker: watches the request and result channels of sorted_multiset_table,
// keeps its own sorted store, predicts each result and compares it field by field.
// Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  smt_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  smt_pkg::rsp_item_type rsp_item,
   output int                    fail_count,
   output int                    pending,
   output int                    checked,
   output int                    full_drops,
   output int                    misses
);

   int                    held_values[$];    // ascending, duplicates allowed
   smt_pkg::rsp_item_type awaited_rsp[$];    // oldest first

   // Apply one request to the local store and return the result it must give
   function automatic smt_pkg::rsp_item_type apply_request(input smt_pkg::req_item_type r);
      smt_pkg::rsp_item_type res;
      int                    pos;
      int                    operand;
      res     = '0;
      operand = r.value;
      pos     = 0;
      res.status = smt_pkg::STAT_DONE;
      case (r.req_type)
         smt_pkg::REQ_INSERT: begin
            if (held_values.size() >= CAPACITY) begin
               res.status = smt_pkg::STAT_FULL;
            end else begin
               // after every equal value
               while (pos < held_values.size() && held_values[pos] <= operand) pos++;
               held_values.insert(pos, operand);
            end
         end
         smt_pkg::REQ_REMOVE: begin
            while (pos < held_values.size() && held_values[pos] != operand) pos++;
            if (pos >= held_values.size()) res.status = smt_pkg::STAT_NOT_FOUND;
            else held_values.delete(pos);
         end
         smt_pkg::REQ_CLEAR: held_values.delete();
         default: ;  // unused code: no change
      endcase
      res.occupancy = 7'(held_values.size());
      if (held_values.size() > 0) begin
         res.smallest_valid = 1'b1;
         res.smallest_value = held_values[0];
      end
      return res;
   endfunction

   task automatic check_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // Results are retired before requests are logged: a result can never
   // belong to a request taken at the same edge
   always @(posedge clock) begin : watch
      smt_pkg::rsp_item_type want;
      if (reset) begin
         held_values.delete();
         awaited_rsp.delete();
         fail_count = 0;
         pending    = 0;
         checked    = 0;
         full_drops = 0;
         misses     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: result with none outstanding, expected nothing, got %h",
                        $time, rsp_item);
            end else begin
               want = awaited_rsp.pop_front();
               checked++;
               check_field("status", want.status, rsp_item.status);
               check_field("occupancy", want.occupancy, rsp_item.occupancy);
               check_field("smallest_valid", want.smallest_valid, rsp_item.smallest_valid);
               check_field("smallest_value", want.smallest_value, rsp_item.smallest_value);
            end
         end
         if (req_valid && req_ready) begin
            want = apply_request(req_item);
            if (want.status == smt_pkg::STAT_FULL) full_drops++;
            if (want.status == smt_pkg::STAT_NOT_FOUND) misses++;
            awaited_rsp.push_back(want);
         end
         pending = awaited_rsp.size();
      end
   end

endmodule

// ===== test/sorted_multiset_table_tb.sv =====
// sorted_multiset_table_tb: drives requests into sorted_multiset_table with random
// idling on both channels and gives the verdict. Depends on smt_pkg, smt_checker.
`timescale 1ns / 1ps

module sorted_multiset_table_tb;

   localparam int         CAPACITY     = 64;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 1530;
   localparam int         CALM_TAIL    = 200;  // last items with no idling
   localparam int         LONG_HOLD    = 300;  // receiver hold-off, cycles
   localparam int         DRAIN_CYCLES = 200;
   // Longest correct stretch without a handshake: the long hold-off plus one
   // full-depth insert plus a sender gap; taken many times over
   localparam int         STALL_LIMIT  = 4000;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_kind_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   smt_pkg::req_item_type req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   smt_pkg::rsp_item_type rsp_item;

   int fail_count, pending, checked, full_drops, misses;

   int          sent_by_kind[4];
   int          hold_off_asks = 0;
   bit          calm          = 1'b0;
   int          gap_odds      = 4;
   logic [31:0] value_pool[16];
   int          pool_size     = 16;
   int          idle_cycles   = 0;

   sorted_multiset_table #(.CAPACITY(CAPACITY)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   smt_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .full_drops (full_drops),
      .misses     (misses)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: short random stalls, stall-free stretches, one long hold-off
   initial begin : result_sink
      int stall;
      int rx_odds;
      int steps_in_mode;
      int hold_offs_done;
      rx_odds        = 4;
      steps_in_mode  = 0;
      hold_offs_done = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = 0;
         if (hold_offs_done != hold_off_asks) begin
            hold_offs_done++;
            stall = LONG_HOLD;
         end else if (!calm && rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
            stall = $urandom_range(1, 6);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         steps_in_mode++;
         if (steps_in_mode == 100) begin
            steps_in_mode = 0;
            case ($urandom_range(0, 2))
               0: rx_odds = 0;
               1: rx_odds = 3;
               default: rx_odds = 6;
            endcase
         end
      end
   end

   // Offer one item, starting and ending at a falling edge
   task automatic send_req(input logic [1:0] kind, input logic [31:0] operand);
      int gap;
      gap = 0;
      if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_item.req_type <= kind;
      req_item.value    <= operand;
      do @(posedge clock); while (!req_ready);
      sent_by_kind[kind]++;
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Small pools give duplicates and removes that hit
   task automatic refresh_pool();
      pool_size = $urandom_range(2, 16);
      for (int i = 0; i < 16; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               case ($urandom_range(0, 3))
                  0: value_pool[i] = 32'h8000_0000;
                  1: value_pool[i] = 32'h7FFF_FFFF;
                  2: value_pool[i] = 32'h0000_0000;
                  default: value_pool[i] = 32'hFFFF_FFFF;
               endcase
            end
            1: value_pool[i] = $urandom_range(0, 32) - 16;
            default: value_pool[i] = $urandom;
         endcase
      end
   endtask

   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return value_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   function automatic logic [1:0] pick_kind(input mix_kind_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (roll < 86) return smt_pkg::REQ_INSERT;
            if (roll < 97) return smt_pkg::REQ_REMOVE;
            if (roll < 98) return smt_pkg::REQ_CLEAR;
         end
         MIX_DRAIN: begin
            if (roll < 80) return smt_pkg::REQ_REMOVE;
            if (roll < 95) return smt_pkg::REQ_INSERT;
            if (roll < 98) return smt_pkg::REQ_CLEAR;
         end
         default: begin
            if (roll < 48) return smt_pkg::REQ_INSERT;
            if (roll < 94) return smt_pkg::REQ_REMOVE;
            if (roll < 97) return smt_pkg::REQ_CLEAR;
         end
      endcase
      return REQ_UNUSED;
   endfunction

   initial begin : stimulus
      mix_kind_type mix;
      int           mix_len;
      int           counted;
      int           offered;
      logic [1:0]   kind;
      counted = 0;
      offered = 0;
      for (int i = 0; i < 4; i++) sent_by_kind[i] = 0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty-store cases, extremes, duplicates, last-entry removal
      send_req(smt_pkg::REQ_REMOVE, 32'd0);
      send_req(smt_pkg::REQ_CLEAR,  32'd0);
      send_req(REQ_UNUSED,          32'hFFFF_FFFF);
      send_req(smt_pkg::REQ_INSERT, 32'd0);
      send_req(smt_pkg::REQ_INSERT, 32'h8000_0000);
      send_req(smt_pkg::REQ_INSERT, 32'h7FFF_FFFF);
      send_req(smt_pkg::REQ_INSERT, 32'hFFFF_FFFF);
      send_req(smt_pkg::REQ_INSERT, 32'd1);
      send_req(smt_pkg::REQ_INSERT, 32'd5);
      send_req(smt_pkg::REQ_INSERT, 32'd5);
      send_req(smt_pkg::REQ_REMOVE, 32'd5);
      send_req(smt_pkg::REQ_REMOVE, 32'd7);
      send_req(REQ_UNUSED,          32'd5);
      send_req(smt_pkg::REQ_REMOVE, 32'h8000_0000);
      send_req(smt_pkg::REQ_REMOVE, 32'h7FFF_FFFF);
      send_req(smt_pkg::REQ_INSERT, 32'h8000_0000);
      send_req(smt_pkg::REQ_REMOVE, 32'd0);
      send_req(smt_pkg::REQ_CLEAR,  32'hA5A5_A5A5);
      send_req(smt_pkg::REQ_INSERT, 32'd42);
      send_req(smt_pkg::REQ_REMOVE, 32'd42);
      send_req(smt_pkg::REQ_REMOVE, 32'd42);
      send_req(smt_pkg::REQ_INSERT, 32'h7FFF_FFFF);
      send_req(smt_pkg::REQ_REMOVE, 32'h7FFF_FFFF);
      wait_all_results();

      // Random: runs of fill, drain and churn; the first run is a fill
      mix = MIX_FILL;
      mix_len = 100;
      while (counted < RANDOM_ITEMS) begin
         refresh_pool();
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 3;
            default: gap_odds = 8;
         endcase
         for (int i = 0; i < mix_len && counted < RANDOM_ITEMS; i++) begin
            calm = (counted >= RANDOM_ITEMS - CALM_TAIL);
            if (offered == 400) hold_off_asks = hold_off_asks + 1;
            if (offered == 900) wait_all_results();
            kind = pick_kind(mix);
            send_req(kind, pick_value());
            offered++;
            if (kind != REQ_UNUSED) counted++;
         end
         case ($urandom_range(0, 2))
            0: mix = MIX_FILL;
            1: mix = MIX_DRAIN;
            default: mix = MIX_CHURN;
         endcase
         mix_len = $urandom_range(30, 120);
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d inserts, %0d removes, %0d clears, %0d unused codes",
               sent_by_kind[smt_pkg::REQ_INSERT], sent_by_kind[smt_pkg::REQ_REMOVE],
               sent_by_kind[smt_pkg::REQ_CLEAR], sent_by_kind[REQ_UNUSED]);
      $display("%0d results checked; inserts dropped on a full store: %0d, %s %0d",
               checked, full_drops, "removes of absent values:", misses);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
